@@ hdl/flg_pkg.sv @@
// Shared types, constants and the sine table for the stereo flanger.
package flg_pkg;

  // Sample and delay-line geometry
  localparam int SAMPLE_W    = 24;
  localparam int DELAY_DEPTH = 4096;
  localparam int ADDR_W      = $clog2(DELAY_DEPTH);
  localparam int FRAC_BITS   = 8;
  localparam int POS_W       = ADDR_W + FRAC_BITS;

  // LFO
  localparam int PHASE_W    = 32;
  localparam int SINE_SIZE  = 256;
  localparam int SINE_IDX_W = $clog2(SINE_SIZE);
  localparam int SINE_W     = 16;

  // Configuration register widths and reset values
  localparam int STEP_W     = 31;
  localparam int DLY_CFG_W  = 20;
  localparam int GAIN_W     = 16;
  localparam int MIX_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;
  localparam logic [DLY_CFG_W-1:0] BASE_RESET = DLY_CFG_W'(256);
  localparam logic [MIX_W-1:0]     MIX_RESET  = MIX_W'(16384);
  localparam int MIX_FULL  = 32768;
  localparam int MIX_EXT_W = MIX_W + 1;

  // Shared multiplier geometry
  localparam int MUL_A_W   = SAMPLE_W + 1;
  localparam int MUL_B_W   = 17;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int Q15_SHIFT = 15;
  localparam int SUM_W     = SAMPLE_W + 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PHASE_STEP    = 3'd0,
    REG_DEPTH_DELAY   = 3'd1,
    REG_BASE_DELAY    = 3'd2,
    REG_FEEDBACK_GAIN = 3'd3,
    REG_WET_MIX       = 3'd4
  } cfg_reg_e;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [SINE_W-1:0]   sine_t;
  typedef sine_t sine_lut_t [SINE_SIZE];

  typedef struct packed {
    sample_t left_sample;
    sample_t right_sample;
  } in_frame_t;

  typedef struct packed {
    sample_t left_out;
    sample_t right_out;
  } out_frame_t;

  // Clamp a wide sum to the sample range
  function automatic sample_t sat_sample(logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(signed'({1'b0, {(SAMPLE_W-1){1'b1}}}));
    lo = SUM_W'(signed'({1'b1, {(SAMPLE_W-1){1'b0}}}));
    if (v > hi) begin
      return sample_t'(hi);
    end else if (v < lo) begin
      return sample_t'(lo);
    end
    return sample_t'(v);
  endfunction

  // Q15 sine per quantized phase step: Taylor series to x^9 in Q30.
  // Evaluated at elaboration only.
  function automatic sine_lut_t build_sine_lut();
    sine_lut_t lut;
    logic [63:0] a;
    logic [63:0] t;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] r;
    logic [63:0] one;
    logic [1:0]  quad;
    one = 64'd1 << 30;
    for (int k = 0; k < SINE_SIZE; k++) begin
      a    = (64'(k) << 32) / 64'(SINE_SIZE);
      quad = a[31:30];
      t    = (a >> 14) & 64'hFFFF;
      if (quad[0]) begin
        t = 64'd65536 - t;
      end
      x    = (t * 64'd1686629713) >> 16;
      x2   = (x * x) >> 30;
      term = one - x2 / 64'd72;
      term = one - ((x2 * term) >> 30) / 64'd42;
      term = one - ((x2 * term) >> 30) / 64'd20;
      term = one - ((x2 * term) >> 30) / 64'd6;
      r    = (x * term) >> 30;
      r    = (r + 64'd16384) >> 15;
      if (r > 64'd32767) begin
        r = 64'd32767;
      end
      lut[k] = quad[1] ? sine_t'(64'd0 - r) : sine_t'(r);
    end
    return lut;
  endfunction

  localparam sine_lut_t SINE_LUT = build_sine_lut();

endpackage

@@ hdl/flg_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module flg_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hdl/stereo_flanger.sv @@
// Stereo feedback flanger with sine LFO, built around one shared multiplier.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------------
//  in       | in_valid_i / in_ready_o   | in_data_i  (left/right sample)
//  out      | out_valid_o / out_ready_i | out_data_o (left/right mix)
//  cfg      | cfg_we_i (no wait)        | cfg_idx_i, cfg_data_i
//
// A sequencer steps each frame from input transfer to the next possible input
// transfer, running seven products through the single 25x17 multiplier.
// Output sits in its own register, so a new frame is taken while a result waits.
// The last step stalls only while a previous result is still not transferred.
// Reset is asynchronous; no clearing pass: delay entries not yet written since
// reset read as zero, tracked by the write pointer and a wrapped flag.
module stereo_flanger (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  flg_pkg::in_frame_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output flg_pkg::out_frame_t           out_data_o,
  input  logic                          cfg_we_i,
  input  logic [flg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [flg_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  // Sequencer: at most one multiply issued per step, its product consumed next step.
  typedef enum logic [3:0] {
    ST_IDLE,   // wait for a frame, fetch the sine
    ST_DEPTH,  // depth * sine
    ST_ADDR,   // read position from delay
    ST_RD1,    // read tap i1
    ST_RD2,    // read tap i2, capture i1
    ST_CAP,    // capture i2
    ST_IL,     // left interpolation product
    ST_IR,     // right interpolation product, finish left delayed sample
    ST_FL,     // left feedback product, finish right delayed sample
    ST_FR,     // right feedback product, left write-back value
    ST_ML,     // left mix product, right write-back value
    ST_MR,     // right mix product, left output, write both lines
    ST_LAST    // right output, hand off to output register
  } state_e;

  state_e state_q, state_d;

  // Configuration
  logic [flg_pkg::STEP_W-1:0]    step_q;
  logic [flg_pkg::DLY_CFG_W-1:0] depth_q;
  logic [flg_pkg::DLY_CFG_W-1:0] base_q;
  logic signed [flg_pkg::GAIN_W-1:0] gain_q;
  logic [flg_pkg::MIX_W-1:0]     wet_q;

  // Control state
  logic [flg_pkg::ADDR_W-1:0]  wp_q;
  logic                        wrapped_q;
  logic [flg_pkg::PHASE_W-1:0] phase_q;
  logic                        out_valid_q;
  flg_pkg::out_frame_t         out_q;

  // Datapath payload
  flg_pkg::in_frame_t          in_q;
  flg_pkg::sine_t              sine_q;
  logic [flg_pkg::POS_W-1:0]   rp_q;
  flg_pkg::sample_t            s1l_q, s1r_q, s2l_q, s2r_q;
  flg_pkg::sample_t            dlyl_q, dlyr_q;
  flg_pkg::sample_t            wbl_q, wbr_q;
  flg_pkg::sample_t            outl_q;
  logic signed [flg_pkg::PROD_W-1:0] prod_q;

  // Shared multiplier
  logic signed [flg_pkg::MUL_A_W-1:0] mul_a;
  logic signed [flg_pkg::MUL_B_W-1:0] mul_b;
  logic signed [flg_pkg::PROD_W-1:0]  prod_d;
  logic signed [flg_pkg::PROD_W-1:0]  sh15, sh8;

  logic                         in_xfer;
  logic                         out_free;
  logic [flg_pkg::MIX_EXT_W-1:0] mix_eff;

  // Delay line access
  logic [flg_pkg::ADDR_W-1:0]   i1, i2, rd_idx, raddr;
  logic                         rd_hit, rd_old;
  flg_pkg::sample_t             ram_l_rdata, ram_r_rdata;
  flg_pkg::sample_t             tap_l, tap_r;
  logic                         ram_we;

  logic signed [flg_pkg::SUM_W-1:0]    sum_l, sum_r;
  logic signed [flg_pkg::MUL_A_W-1:0]  itp_l, itp_r;
  logic [flg_pkg::POS_W-1:0]           rp_d;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Wet share above all-wet counts as all-wet
  assign mix_eff = (wet_q > flg_pkg::MIX_W'(flg_pkg::MIX_FULL))
                 ? flg_pkg::MIX_EXT_W'(flg_pkg::MIX_FULL)
                 : flg_pkg::MIX_EXT_W'(wet_q);

  // Operand selection per step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_DEPTH: begin
        mul_a = signed'(flg_pkg::MUL_A_W'(depth_q));
        mul_b = flg_pkg::MUL_B_W'(sine_q);
      end
      ST_IL: begin
        mul_a = flg_pkg::MUL_A_W'(s2l_q) - flg_pkg::MUL_A_W'(s1l_q);
        mul_b = signed'(flg_pkg::MUL_B_W'(rp_q[flg_pkg::FRAC_BITS-1:0]));
      end
      ST_IR: begin
        mul_a = flg_pkg::MUL_A_W'(s2r_q) - flg_pkg::MUL_A_W'(s1r_q);
        mul_b = signed'(flg_pkg::MUL_B_W'(rp_q[flg_pkg::FRAC_BITS-1:0]));
      end
      ST_FL: begin
        mul_a = flg_pkg::MUL_A_W'(dlyl_q);
        mul_b = flg_pkg::MUL_B_W'(gain_q);
      end
      ST_FR: begin
        mul_a = flg_pkg::MUL_A_W'(dlyr_q);
        mul_b = flg_pkg::MUL_B_W'(gain_q);
      end
      ST_ML: begin
        // in*(1-m) + d*m == in + (d-in)*m, exact under the floor shift
        mul_a = flg_pkg::MUL_A_W'(dlyl_q) - flg_pkg::MUL_A_W'(in_q.left_sample);
        mul_b = signed'(mix_eff);
      end
      ST_MR, ST_LAST: begin
        // held through LAST so a stalled hand-off keeps its product
        mul_a = flg_pkg::MUL_A_W'(dlyr_q) - flg_pkg::MUL_A_W'(in_q.right_sample);
        mul_b = signed'(mix_eff);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = mul_a * mul_b;
  assign sh15   = prod_q >>> flg_pkg::Q15_SHIFT;
  assign sh8    = prod_q >>> flg_pkg::FRAC_BITS;

  // Post-processing of the previous product
  assign sum_l = flg_pkg::SUM_W'(signed'(in_q.left_sample)) + flg_pkg::SUM_W'(sh15);
  assign sum_r = flg_pkg::SUM_W'(signed'(in_q.right_sample)) + flg_pkg::SUM_W'(sh15);
  assign itp_l = flg_pkg::MUL_A_W'(s1l_q) + flg_pkg::MUL_A_W'(sh8);
  assign itp_r = flg_pkg::MUL_A_W'(s1r_q) + flg_pkg::MUL_A_W'(sh8);

  // Read position modulo the line length; negative and long delays wrap
  assign rp_d = flg_pkg::POS_W'({wp_q, {flg_pkg::FRAC_BITS{1'b0}}})
              - flg_pkg::POS_W'(base_q) - flg_pkg::POS_W'(sh15);

  // Tap addressing: the current slot holds this frame's input,
  // slots never written since reset hold zero.
  assign i1     = rp_q[flg_pkg::POS_W-1 -: flg_pkg::ADDR_W];
  assign i2     = i1 + flg_pkg::ADDR_W'(1);
  assign raddr  = (state_q == ST_RD2) ? i2 : i1;
  assign rd_idx = (state_q == ST_CAP) ? i2 : i1;
  assign rd_hit = (rd_idx == wp_q);
  assign rd_old = wrapped_q || (rd_idx < wp_q);

  always_comb begin
    if (rd_hit) begin
      tap_l = in_q.left_sample;
      tap_r = in_q.right_sample;
    end else if (rd_old) begin
      tap_l = ram_l_rdata;
      tap_r = ram_r_rdata;
    end else begin
      tap_l = '0;
      tap_r = '0;
    end
  end

  assign ram_we = (state_q == ST_MR);

  flg_ram #(
    .WIDTH (flg_pkg::SAMPLE_W),
    .DEPTH (flg_pkg::DELAY_DEPTH)
  ) u_ram_l (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (wbl_q),
    .raddr_i (raddr),
    .rdata_o (ram_l_rdata)
  );

  flg_ram #(
    .WIDTH (flg_pkg::SAMPLE_W),
    .DEPTH (flg_pkg::DELAY_DEPTH)
  ) u_ram_r (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wp_q),
    .wdata_i (wbr_q),
    .raddr_i (raddr),
    .rdata_o (ram_r_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_xfer) state_d = ST_DEPTH;
      ST_DEPTH: state_d = ST_ADDR;
      ST_ADDR:  state_d = ST_RD1;
      ST_RD1:   state_d = ST_RD2;
      ST_RD2:   state_d = ST_CAP;
      ST_CAP:   state_d = ST_IL;
      ST_IL:    state_d = ST_IR;
      ST_IR:    state_d = ST_FL;
      ST_FL:    state_d = ST_FR;
      ST_FR:    state_d = ST_ML;
      ST_ML:    state_d = ST_MR;
      ST_MR:    state_d = ST_LAST;
      ST_LAST:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Control state, configuration and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      depth_q     <= '0;
      base_q      <= flg_pkg::BASE_RESET;
      gain_q      <= '0;
      wet_q       <= flg_pkg::MIX_RESET;
      wp_q        <= '0;
      wrapped_q   <= 1'b0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (flg_pkg::cfg_reg_e'(cfg_idx_i))
          flg_pkg::REG_PHASE_STEP:    step_q  <= cfg_data_i[flg_pkg::STEP_W-1:0];
          flg_pkg::REG_DEPTH_DELAY:   depth_q <= cfg_data_i[flg_pkg::DLY_CFG_W-1:0];
          flg_pkg::REG_BASE_DELAY:    base_q  <= cfg_data_i[flg_pkg::DLY_CFG_W-1:0];
          flg_pkg::REG_FEEDBACK_GAIN: gain_q  <= signed'(cfg_data_i[flg_pkg::GAIN_W-1:0]);
          flg_pkg::REG_WET_MIX:       wet_q   <= cfg_data_i[flg_pkg::MIX_W-1:0];
          default: ;
        endcase
      end

      if (state_q == ST_LAST && out_free) begin
        out_valid_q     <= 1'b1;
        out_q.left_out  <= outl_q;
        out_q.right_out <= flg_pkg::sat_sample(sum_r);
        wp_q            <= wp_q + flg_pkg::ADDR_W'(1);
        if (wp_q == flg_pkg::ADDR_W'(flg_pkg::DELAY_DEPTH - 1)) begin
          wrapped_q <= 1'b1;
        end
        phase_q <= phase_q + flg_pkg::PHASE_W'(step_q);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          in_q   <= in_data_i;
          sine_q <= flg_pkg::SINE_LUT[phase_q[flg_pkg::PHASE_W-1 -: flg_pkg::SINE_IDX_W]];
        end
      end
      ST_ADDR: rp_q <= rp_d;
      ST_RD2: begin
        s1l_q <= tap_l;
        s1r_q <= tap_r;
      end
      ST_CAP: begin
        s2l_q <= tap_l;
        s2r_q <= tap_r;
      end
      ST_IR:  dlyl_q <= flg_pkg::sample_t'(itp_l);
      ST_FL:  dlyr_q <= flg_pkg::sample_t'(itp_r);
      ST_FR:  wbl_q  <= flg_pkg::sat_sample(sum_l);
      ST_ML:  wbr_q  <= flg_pkg::sat_sample(sum_r);
      ST_MR:  outl_q <= flg_pkg::sat_sample(sum_l);
      default: ;
    endcase
  end

endmodule

@@ hdl/flg_checker.sv @@
// Port-level checks for the stereo flanger, bound to its top level.
module flg_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input flg_pkg::out_frame_t out_data_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output changed while stalled");

  // After a transfer in, the unit is busy
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a frame is in flight");

  // A new result only appears at the end of a frame's work
  a_out_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a frame in flight");

  // No result shows up right after a frame is taken
  a_no_instant_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared one cycle after input");

endmodule

bind stereo_flanger flg_checker u_flg_checker (.*);

@@ sim/stereo_flanger_tb.sv @@
// Self-checking testbench for the stereo feedback flanger.
module stereo_flanger_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Pause taken once everything has drained, before the registers are rewritten
  localparam int DRAIN_CYCLES = 32;
  localparam int HOLD_CYCLES  = 250;
  localparam int PHASE_FRAMES = 245;
  localparam logic [flg_pkg::STEP_W-1:0] STEP_MAX  = '1;
  localparam logic [flg_pkg::DLY_CFG_W-1:0] DLY_MAX = '1;
  localparam flg_pkg::sample_t SAMPLE_MAX = 24'sh7FFFFF;
  localparam flg_pkg::sample_t SAMPLE_MIN = 24'sh800000;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          in_valid_i = 1'b0;
  logic          in_ready_o;
  flg_pkg::in_frame_t  in_data_i = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  flg_pkg::out_frame_t out_data_o;
  logic          cfg_we_i = 1'b0;
  flg_pkg::cfg_reg_e   cfg_idx_i = flg_pkg::REG_PHASE_STEP;
  logic [flg_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  stereo_flanger dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs; far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Shadow copy of the flanger: delay lines, write pointer, LFO accumulator
  // and the register file as last programmed.
  // ---------------------------------------------------------------------------
  flg_pkg::sample_t                echo_mem [2][flg_pkg::DELAY_DEPTH];
  logic [flg_pkg::ADDR_W-1:0]      wr_ptr = '0;
  logic [flg_pkg::PHASE_W-1:0]     lfo_acc = '0;
  logic [flg_pkg::STEP_W-1:0]      cfg_step = '0;
  logic [flg_pkg::DLY_CFG_W-1:0]   cfg_depth = '0;
  logic [flg_pkg::DLY_CFG_W-1:0]   cfg_base = flg_pkg::BASE_RESET;
  logic signed [flg_pkg::GAIN_W-1:0] cfg_gain = '0;
  logic [flg_pkg::MIX_W-1:0]       cfg_mix = flg_pkg::MIX_RESET;

  flg_pkg::in_frame_t  pending_frames [$];   // frames waiting to be offered
  flg_pkg::out_frame_t expected_mix [$];     // predicted outputs, oldest first
  flg_pkg::out_frame_t want;
  int         frames_sent = 0;
  int         results_seen = 0;
  int         hold_left = 0;
  int         err_count = 0;

  // Q15 sine of the quantized LFO phase. Only the top 8 phase bits matter:
  // bits 7:6 pick the quadrant, bits 5:0 the position inside it.
  function automatic logic signed [flg_pkg::SINE_W-1:0] lfo_sine(
      logic [flg_pkg::PHASE_W-1:0] phase);
    logic [flg_pkg::SINE_IDX_W-1:0] k;
    logic [63:0] t;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] r;
    k = phase[flg_pkg::PHASE_W-1 -: flg_pkg::SINE_IDX_W];
    t = 64'(k[5:0]) << 10;
    if (k[6]) begin
      t = 64'd65536 - t;   // mirror in odd quadrants
    end
    // angle in Q30 radians: pi/2 * t / 2^16
    x    = (t * 64'd1686629713) >> 16;
    x2   = (x * x) >> 30;
    term = (64'd1 << 30) - x2 / 64'd72;
    term = (64'd1 << 30) - ((x2 * term) >> 30) / 64'd42;
    term = (64'd1 << 30) - ((x2 * term) >> 30) / 64'd20;
    term = (64'd1 << 30) - ((x2 * term) >> 30) / 64'd6;
    r    = (((x * term) >> 30) + 64'd16384) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    return k[7] ? -flg_pkg::SINE_W'(r) : flg_pkg::SINE_W'(r);
  endfunction

  function automatic flg_pkg::sample_t clip_sample(longint v);
    if (v > 8388607) begin
      return SAMPLE_MAX;
    end
    if (v < -8388608) begin
      return SAMPLE_MIN;
    end
    return flg_pkg::sample_t'(v);
  endfunction

  // One channel: write input, interpolated tap read, feedback write-back, mix.
  function automatic flg_pkg::sample_t flange_channel(int ch, flg_pkg::sample_t x,
                                                      longint dly, longint mix);
    logic [flg_pkg::POS_W-1:0]  rd_pos;
    logic [flg_pkg::ADDR_W-1:0] tap_a;
    logic [flg_pkg::ADDR_W-1:0] tap_b;
    longint s1;
    longint s2;
    longint wet;
    longint dry;
    dry = x;
    echo_mem[ch][wr_ptr] = x;
    // truncation to POS_W bits wraps negative and oversized delays
    rd_pos = flg_pkg::POS_W'((longint'(wr_ptr) << flg_pkg::FRAC_BITS) - dly);
    tap_a  = rd_pos[flg_pkg::POS_W-1:flg_pkg::FRAC_BITS];
    tap_b  = tap_a + flg_pkg::ADDR_W'(1);
    s1  = echo_mem[ch][tap_a];
    s2  = echo_mem[ch][tap_b];
    wet = s1 + (((s2 - s1) * longint'(rd_pos[flg_pkg::FRAC_BITS-1:0])) >>> flg_pkg::FRAC_BITS);
    echo_mem[ch][wr_ptr] =
      clip_sample(dry + ((wet * longint'(cfg_gain)) >>> flg_pkg::Q15_SHIFT));
    return clip_sample((dry * (flg_pkg::MIX_FULL - mix) + wet * mix) >>> flg_pkg::Q15_SHIFT);
  endfunction

  function automatic void predict_flange(flg_pkg::in_frame_t f);
    longint dly;
    longint mix;
    flg_pkg::out_frame_t y;
    // floor(depth * sine / 2^15) on both signs of the sine
    dly = longint'(cfg_base)
        + ((longint'(cfg_depth) * longint'(lfo_sine(lfo_acc))) >>> flg_pkg::Q15_SHIFT);
    mix = (cfg_mix > flg_pkg::MIX_FULL) ? flg_pkg::MIX_FULL : longint'(cfg_mix);
    y.left_out  = flange_channel(0, f.left_sample, dly, mix);
    y.right_out = flange_channel(1, f.right_sample, dly, mix);
    expected_mix.push_back(y);
    wr_ptr  = wr_ptr + flg_pkg::ADDR_W'(1);
    lfo_acc = lfo_acc + flg_pkg::PHASE_W'(cfg_step);
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver. Takes the next pending frame once the current one has been
  // transferred; idles about a quarter of the time outside the burst window.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_flange(in_data_i);
        frames_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_frames.size() != 0 &&
            ((frames_sent >= 500 && frames_sent < 800) || $urandom_range(99) >= 25)) begin
          in_valid_i <= 1'b1;
          in_data_i  <= pending_frames.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor and receiver. Checks every transfer against the oldest
  // prediction; twice it holds ready low for a long stretch so the block's
  // output register and input stage back up.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (expected_mix.size() == 0) begin
          $error("output frame %h with nothing predicted", out_data_o);
          err_count++;
        end else begin
          want = expected_mix.pop_front();
          if (out_data_o.left_out !== want.left_out) begin
            $error("left_out: expected %0d, got %0d", want.left_out, out_data_o.left_out);
            err_count++;
          end
          if (out_data_o.right_out !== want.right_out) begin
            $error("right_out: expected %0d, got %0d", want.right_out, out_data_o.right_out);
            err_count++;
          end
        end
        if (results_seen == 300 || results_seen == 1000) begin
          hold_left = HOLD_CYCLES;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= (results_seen >= 500 && results_seen < 800) || $urandom_range(99) >= 25;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_frame(flg_pkg::sample_t l, flg_pkg::sample_t r);
    pending_frames.push_back('{left_sample: l, right_sample: r});
  endtask

  function automatic flg_pkg::sample_t draw_sample();
    case ($urandom_range(7))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return flg_pkg::sample_t'(int'($urandom_range(8191)) - 4096);
      default: return flg_pkg::sample_t'($urandom);
    endcase
  endfunction

  // Sender pause: nothing pending, nothing in flight, then a drain pause.
  task automatic wait_drained();
    while (pending_frames.size() != 0 || in_valid_i || expected_mix.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(flg_pkg::cfg_reg_e idx, logic [flg_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
  endtask

  // Reprogram all registers once the block is idle; mirror them for prediction.
  task automatic program_regs(logic [flg_pkg::STEP_W-1:0] step,
                              logic [flg_pkg::DLY_CFG_W-1:0] depth,
                              logic [flg_pkg::DLY_CFG_W-1:0] base,
                              logic [flg_pkg::GAIN_W-1:0] gain,
                              logic [flg_pkg::MIX_W-1:0] mix);
    wait_drained();
    write_reg(flg_pkg::REG_PHASE_STEP, flg_pkg::CFG_DATA_W'(step));
    write_reg(flg_pkg::REG_DEPTH_DELAY, flg_pkg::CFG_DATA_W'(depth));
    write_reg(flg_pkg::REG_BASE_DELAY, flg_pkg::CFG_DATA_W'(base));
    write_reg(flg_pkg::REG_FEEDBACK_GAIN, flg_pkg::CFG_DATA_W'(gain));
    write_reg(flg_pkg::REG_WET_MIX, flg_pkg::CFG_DATA_W'(mix));
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    cfg_step  = step;
    cfg_depth = depth;
    cfg_base  = base;
    cfg_gain  = gain;
    cfg_mix   = mix;
  endtask

  task automatic push_random_frames(int n);
    for (int i = 0; i < n; i++) begin
      push_frame(draw_sample(), draw_sample());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int c = 0; c < 2; c++) begin
      for (int a = 0; a < flg_pkg::DELAY_DEPTH; a++) begin
        echo_mem[c][a] = '0;
      end
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: one-sample delay, half wet. Sample extremes.
    push_frame(SAMPLE_MAX, SAMPLE_MAX);
    push_frame(SAMPLE_MIN, SAMPLE_MIN);
    push_frame(SAMPLE_MAX, SAMPLE_MIN);
    push_frame('0, '0);
    push_frame(-24'sd1, 24'sd1);
    push_frame(SAMPLE_MIN, SAMPLE_MAX);

    // Zero delay, LFO frozen, strongest positive feedback, wet beyond full
    // (must clamp to all wet).
    program_regs('0, '0, '0, 16'h7FFF, 16'hFFFF);
    push_frame(SAMPLE_MAX, SAMPLE_MIN);
    push_frame(SAMPLE_MAX, SAMPLE_MIN);
    push_frame(SAMPLE_MIN, SAMPLE_MAX);
    push_frame(24'sd1, -24'sd1);
    push_frame('0, '0);

    // Fastest LFO, full depth around zero: delays swing negative and wrap.
    // Most negative feedback, fully dry output.
    program_regs(STEP_MAX, DLY_MAX, '0, 16'h8000, '0);
    for (int i = 0; i < 4; i++) begin
      push_frame(SAMPLE_MAX, SAMPLE_MIN);
      push_frame(SAMPLE_MIN, SAMPLE_MAX);
    end

    // Largest base delay wraps past the store; exactly all wet.
    program_regs(flg_pkg::STEP_W'(1 << 24), '0, DLY_MAX, 16'h7FFF, 16'(flg_pkg::MIX_FULL));
    push_frame(SAMPLE_MAX, SAMPLE_MAX);
    push_frame(SAMPLE_MIN, SAMPLE_MIN);
    push_frame(-24'sd1, SAMPLE_MAX);
    push_frame(SAMPLE_MAX, -24'sd1);
    push_frame('0, SAMPLE_MIN);

    // Random phases, each with its own settings.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: program_regs(flg_pkg::STEP_W'($urandom_range(1 << 24, 1 << 16)),
                        flg_pkg::DLY_CFG_W'($urandom_range(16 * 256)),
                        flg_pkg::DLY_CFG_W'($urandom_range(48 * 256, 16 * 256)),
                        flg_pkg::GAIN_W'($urandom),
                        flg_pkg::MIX_W'($urandom_range(flg_pkg::MIX_FULL)));
        1: program_regs('0, flg_pkg::DLY_CFG_W'($urandom), flg_pkg::DLY_CFG_W'($urandom),
                        16'h8000, 16'(flg_pkg::MIX_FULL));
        2: program_regs(flg_pkg::STEP_W'($urandom), flg_pkg::DLY_CFG_W'($urandom),
                        flg_pkg::DLY_CFG_W'($urandom), flg_pkg::GAIN_W'($urandom),
                        flg_pkg::MIX_W'($urandom));
        // small depth around zero: fractional reads lean toward the oldest entry
        3: program_regs(flg_pkg::STEP_W'($urandom),
                        flg_pkg::DLY_CFG_W'($urandom_range(2048, 1)), '0,
                        flg_pkg::GAIN_W'($urandom),
                        flg_pkg::MIX_W'($urandom_range(flg_pkg::MIX_FULL)));
        4: program_regs(flg_pkg::STEP_W'($urandom_range(1 << 28, 1 << 20)),
                        flg_pkg::DLY_CFG_W'($urandom_range(64 * 256)),
                        flg_pkg::DLY_CFG_W'($urandom_range(DLY_MAX, 64 * 256)),
                        16'h7FFF, flg_pkg::MIX_W'($urandom));
        default: program_regs(flg_pkg::STEP_W'($urandom_range(1 << 26, 1 << 16)),
                              flg_pkg::DLY_CFG_W'($urandom_range(32 * 256)),
                              flg_pkg::DLY_CFG_W'($urandom_range(32 * 256)),
                              16'h8000,
                              flg_pkg::MIX_W'($urandom_range(flg_pkg::MIX_FULL)));
      endcase
      push_random_frames(PHASE_FRAMES);
    end

    wait_drained();
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
